/* design/sedm_pkg.sv */
// package for the squared euclidean distance map unit
// constants, request codes and the store command struct; no dependencies
package sedm_pkg;
    localparam int DEF_MAX_COLS = 512;
    localparam int DEF_MAX_ROWS = 512;
    localparam int DIST_W = 31;
    localparam int IDX_W = 18;
    localparam int DIM_W = 10;
    localparam logic [DIST_W-1:0] TOP31 = 31'h7FFF_FFFF;
    localparam logic [DIST_W-1:0] INC_STEP = 31'd2;
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;
    localparam logic CFG_COLS = 1'b0;
    localparam logic CFG_ROWS = 1'b1;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [DIST_W-1:0] wr_data;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } store_cmd_t;
endpackage

/* design/sedm_store.sv */
// distance store: one write port and one read port, registered read data
// depends on sedm_pkg
module sedm_store #(
    parameter int DEPTH = sedm_pkg::DEF_MAX_COLS * sedm_pkg::DEF_MAX_ROWS
) (
    input  logic                        aclk,
    input  sedm_pkg::store_cmd_t        cmd,
    output logic [sedm_pkg::DIST_W-1:0] rd_data
);
    import sedm_pkg::*;
    localparam int AW = $clog2(DEPTH);
    logic [DIST_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[cmd.wr_addr[AW-1:0]] <= cmd.wr_data;
        end
        if (cmd.rd_en) begin
            rd_data <= mem[cmd.rd_addr[AW-1:0]];
        end
    end
endmodule

/* design/sedm_queue.sv */
// index queue memory for the horizontal waves, registered read
// depends on sedm_pkg
module sedm_queue #(
    parameter int DEPTH = sedm_pkg::DEF_MAX_COLS
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [$clog2(DEPTH)-1:0]   wr_data,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [$clog2(DEPTH)-1:0]   rd_data
);
    import sedm_pkg::*;
    logic [$clog2(DEPTH)-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

/* design/sedm_ctrl.sv */
// transform sequencer: init sweep, vertical pass, horizontal waves
// depends on sedm_pkg, drives the store and two queue pairs
module sedm_ctrl #(
    parameter int MAX_COLS = sedm_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = sedm_pkg::DEF_MAX_ROWS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [sedm_pkg::DIM_W-1:0]  num_cols,
    input  logic [sedm_pkg::DIM_W-1:0]  num_rows,
    input  logic [sedm_pkg::DIST_W-1:0] rd_data,
    output sedm_pkg::store_cmd_t        cmd,
    output logic                        busy
);
    import sedm_pkg::*;
    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW1 = $clog2(MAX_COLS + 1);
    localparam int RW1 = $clog2(MAX_ROWS + 1);
    localparam int PW = $clog2(MAX_COLS * MAX_ROWS + 1);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_INITR = 11'b00000000010,
        S_INITW = 11'b00000000100,
        S_VRD0  = 11'b00000001000,
        S_VRD1  = 11'b00000010000,
        S_VCMP  = 11'b00000100000,
        S_HFILL = 11'b00001000000,
        S_HQRD  = 11'b00010000000,
        S_HRD0  = 11'b00100000000,
        S_HRD1  = 11'b01000000000,
        S_HCMP  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic [CW1-1:0] w_reg;
    logic [RW1-1:0] h_reg;
    logic [DIST_W-1:0] large_reg;
    logic [PW-1:0] k_reg, k_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic up_reg, up_next;
    logic west_reg, west_next;
    logic [DIST_W-1:0] inc_reg, inc_next;
    logic [DIST_W-1:0] src_reg, src_next;
    logic [PW-1:0] base_reg, base_next;
    logic [CW-1:0] q_reg, q_next;
    logic [CW1-1:0] ne_reg, ne_next, nw_reg, nw_next;
    logic [CW1-1:0] nen_reg, nen_next, nwn_reg, nwn_next;
    logic [CW-1:0] i_reg, i_next;
    logic bank_reg, bank_next;
    logic [CW1-1:0] w_next_c;
    logic [RW1-1:0] h_next_c;
    logic [DIST_W-1:0] cand;
    logic hit;

    logic [1:0] qe_wr_en, qw_wr_en;
    logic [CW-1:0] qe_wr_addr, qw_wr_addr, qe_wr_data, qw_wr_data;
    logic [CW-1:0] qe_rd_data [2];
    logic [CW-1:0] qw_rd_data [2];
    logic [CW-1:0] q_idx;

    for (genvar b = 0; b < 2; b++) begin : g_bank
        sedm_queue #(.DEPTH(MAX_COLS)) u_qe (
            .aclk(aclk), .wr_en(qe_wr_en[b]), .wr_addr(qe_wr_addr),
            .wr_data(qe_wr_data), .rd_addr(q_reg), .rd_data(qe_rd_data[b])
        );
        sedm_queue #(.DEPTH(MAX_COLS)) u_qw (
            .aclk(aclk), .wr_en(qw_wr_en[b]), .wr_addr(qw_wr_addr),
            .wr_data(qw_wr_data), .rd_addr(q_reg), .rd_data(qw_rd_data[b])
        );
    end

    always_comb begin
        if (num_cols == '0) w_next_c = CW1'(1);
        else if ({22'd0, num_cols} > 32'(MAX_COLS)) w_next_c = CW1'(MAX_COLS);
        else w_next_c = CW1'(num_cols);
        if (num_rows == '0) h_next_c = RW1'(1);
        else if ({22'd0, num_rows} > 32'(MAX_ROWS)) h_next_c = RW1'(MAX_ROWS);
        else h_next_c = RW1'(num_rows);
    end

    assign q_idx = west_reg ? qw_rd_data[bank_reg] : qe_rd_data[bank_reg];
    assign cand = src_reg + inc_reg;
    assign hit = rd_data > cand;
    assign busy = (state_reg != S_IDLE);

    always_comb begin
        state_next = state_reg;
        k_next = k_reg;
        col_next = col_reg;
        row_next = row_reg;
        up_next = up_reg;
        west_next = west_reg;
        inc_next = inc_reg;
        src_next = src_reg;
        base_next = base_reg;
        q_next = q_reg;
        ne_next = ne_reg;
        nw_next = nw_reg;
        nen_next = nen_reg;
        nwn_next = nwn_reg;
        i_next = i_reg;
        bank_next = bank_reg;
        cmd = '0;
        qe_wr_en = '0;
        qw_wr_en = '0;
        qe_wr_addr = '0;
        qw_wr_addr = '0;
        qe_wr_data = '0;
        qw_wr_data = '0;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    k_next = '0;
                    state_next = S_INITR;
                end
            end
            S_INITR: begin
                cmd.rd_en = 1'b1;
                cmd.rd_addr = IDX_W'(k_reg);
                state_next = S_INITW;
            end
            S_INITW: begin
                cmd.wr_en = (rd_data != '0);
                cmd.wr_addr = IDX_W'(k_reg);
                cmd.wr_data = large_reg;
                if (k_reg + PW'(1) == PW'(w_reg) * PW'(h_reg)) begin
                    col_next = '0;
                    up_next = 1'b0;
                    row_next = RW'(1);
                    inc_next = DIST_W'(1);
                    base_next = '0;
                    state_next = (h_reg > RW1'(1)) ? S_VRD0 : S_HFILL;
                    row_next = (h_reg > RW1'(1)) ? RW'(1) : '0;
                end else begin
                    k_next = k_reg + PW'(1);
                    state_next = S_INITR;
                end
            end
            S_VRD0: begin
                // base holds the destination address going up, the column index going down
                cmd.rd_en = 1'b1;
                cmd.rd_addr = up_reg ? IDX_W'(base_reg + PW'(w_reg))
                                     : IDX_W'(base_reg + PW'(w_reg) * PW'(row_reg)
                                              - PW'(w_reg));
                state_next = S_VRD1;
            end
            S_VRD1: begin
                src_next = rd_data;
                cmd.rd_en = 1'b1;
                cmd.rd_addr = up_reg ? IDX_W'(base_reg)
                                     : IDX_W'(base_reg + PW'(w_reg) * PW'(row_reg));
                if (!up_reg) base_next = base_reg + PW'(w_reg) * PW'(row_reg);
                state_next = S_VCMP;
            end
            S_VCMP: begin
                cmd.wr_en = hit;
                cmd.wr_addr = IDX_W'(base_reg);
                cmd.wr_data = cand;
                inc_next = hit ? inc_reg + INC_STEP : DIST_W'(1);
                if (!up_reg) begin
                    base_next = PW'(col_reg);
                    if (RW1'(row_reg) + RW1'(1) == h_reg) begin
                        up_next = 1'b1;
                        inc_next = DIST_W'(1);
                        row_next = RW'(h_reg - RW1'(2));
                        base_next = PW'(col_reg) + PW'(w_reg) * PW'(h_reg - RW1'(2));
                    end else begin
                        row_next = row_reg + RW'(1);
                    end
                    state_next = S_VRD0;
                end else if (row_reg == '0) begin
                    up_next = 1'b0;
                    inc_next = DIST_W'(1);
                    row_next = RW'(1);
                    base_next = '0;
                    if (CW1'(col_reg) + CW1'(1) == w_reg) begin
                        row_next = '0;
                        state_next = S_HFILL;
                    end else begin
                        col_next = col_reg + CW'(1);
                        base_next = PW'(col_reg) + PW'(1);
                        state_next = S_VRD0;
                    end
                end else begin
                    row_next = row_reg - RW'(1);
                    base_next = base_reg - PW'(w_reg);
                    state_next = S_VRD0;
                end
                if (!up_reg && RW1'(row_reg) + RW1'(1) != h_reg) begin
                    base_next = PW'(col_reg);
                end
            end
            S_HFILL: begin
                // seed bank 0 of both queues for row_reg
                base_next = PW'(w_reg) * PW'(row_reg);
                if (w_reg == CW1'(1)) begin
                    if (RW1'(row_reg) + RW1'(1) == h_reg) state_next = S_IDLE;
                    else row_next = row_reg + RW'(1);
                end else begin
                    qe_wr_en[0] = 1'b1;
                    qw_wr_en[0] = 1'b1;
                    qe_wr_addr = q_reg;
                    qw_wr_addr = q_reg;
                    qw_wr_data = q_reg + CW'(1);
                    qe_wr_data = CW'(w_reg - CW1'(2) - CW1'(q_reg));
                    if (CW1'(q_reg) + CW1'(2) == w_reg) begin
                        q_next = '0;
                        ne_next = w_reg - CW1'(1);
                        nw_next = w_reg - CW1'(1);
                        nen_next = '0;
                        nwn_next = '0;
                        inc_next = DIST_W'(1);
                        west_next = 1'b0;
                        bank_next = 1'b0;
                        state_next = S_HQRD;
                    end else begin
                        q_next = q_reg + CW'(1);
                    end
                end
            end
            S_HQRD: begin
                // queue read of q_reg is registered here; S_HRD0 uses the result
                if ((west_reg ? nw_reg : ne_reg) == '0 ||
                    CW1'(q_reg) >= (west_reg ? nw_reg : ne_reg)) begin
                    if (!west_reg) begin
                        west_next = 1'b1;
                        q_next = '0;
                    end else if (nen_reg == '0 && nwn_reg == '0) begin
                        q_next = '0;
                        west_next = 1'b0;
                        if (RW1'(row_reg) + RW1'(1) == h_reg) begin
                            state_next = S_IDLE;
                        end else begin
                            row_next = row_reg + RW'(1);
                            state_next = S_HFILL;
                        end
                    end else begin
                        ne_next = nen_reg;
                        nw_next = nwn_reg;
                        nen_next = '0;
                        nwn_next = '0;
                        bank_next = ~bank_reg;
                        inc_next = inc_reg + INC_STEP;
                        west_next = 1'b0;
                        q_next = '0;
                    end
                end else begin
                    state_next = S_HRD0;
                end
            end
            S_HRD0: begin
                i_next = q_idx;
                cmd.rd_en = 1'b1;
                cmd.rd_addr = IDX_W'(base_reg + PW'(q_idx));
                state_next = S_HRD1;
            end
            S_HRD1: begin
                src_next = rd_data;
                cmd.rd_en = 1'b1;
                cmd.rd_addr = west_reg ? IDX_W'(base_reg + PW'(i_reg) - PW'(1))
                                       : IDX_W'(base_reg + PW'(i_reg) + PW'(1));
                state_next = S_HCMP;
            end
            S_HCMP: begin
                cmd.wr_en = hit;
                cmd.wr_addr = west_reg ? IDX_W'(base_reg + PW'(i_reg) - PW'(1))
                                       : IDX_W'(base_reg + PW'(i_reg) + PW'(1));
                cmd.wr_data = cand;
                if (!west_reg) begin
                    if (hit && CW1'(i_reg) + CW1'(2) < w_reg) begin
                        qe_wr_en[~bank_reg] = 1'b1;
                        qe_wr_addr = CW'(nen_reg);
                        qe_wr_data = i_reg + CW'(1);
                        nen_next = nen_reg + CW1'(1);
                    end
                end else begin
                    if (hit && i_reg > CW'(1)) begin
                        qw_wr_en[~bank_reg] = 1'b1;
                        qw_wr_addr = CW'(nwn_reg);
                        qw_wr_data = i_reg - CW'(1);
                        nwn_next = nwn_reg + CW1'(1);
                    end
                end
                q_next = q_reg + CW'(1);
                state_next = S_HQRD;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        if (state_reg == S_IDLE && start) begin
            w_reg <= w_next_c;
            h_reg <= h_next_c;
            large_reg <= TOP31 - DIST_W'(w_next_c) * DIST_W'(w_next_c)
                               - DIST_W'(h_next_c) * DIST_W'(h_next_c);
            q_reg <= '0;
        end else begin
            q_reg <= q_next;
        end
        k_reg <= k_next;
        col_reg <= col_next;
        row_reg <= row_next;
        up_reg <= up_next;
        west_reg <= west_next;
        inc_reg <= inc_next;
        src_reg <= src_next;
        base_reg <= base_next;
        ne_reg <= ne_next;
        nw_reg <= nw_next;
        nen_reg <= nen_next;
        nwn_reg <= nwn_next;
        i_reg <= i_next;
        bank_reg <= bank_next;
    end
endmodule

/* design/squared_euclidean_distance_map_unit.sv */
// squared euclidean distance map unit, top level
// depends on sedm_pkg, sedm_store, sedm_ctrl
// Loads are taken one per cycle while no transform, start or read is pending and
// the output register is empty. A read returns its distance through a one-entry
// output register, and it holds off the input until that result transfer. A load
// with frame_end starts the transform through start_reg, and the transform stalls
// input while it walks the store: the foreground sweep, the vertical pass (down
// then up each column), then per row the queue seeding and the horizontal waves
// of relaxations.
module squared_euclidean_distance_map_unit #(
    parameter int MAX_COLS = sedm_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = sedm_pkg::DEF_MAX_ROWS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // pixel_index, is_foreground, then zero fill
    input  logic        s_tuser,   // req_type
    input  logic        s_tlast,   // frame_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // squared_distance, then zero fill
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [9:0]  cfg_data
);
    import sedm_pkg::*;
    localparam int DEPTH = MAX_COLS * MAX_ROWS;

    logic [DIM_W-1:0] num_cols_reg, num_rows_reg;
    store_cmd_t io_cmd, tr_cmd, st_cmd;
    logic [DIST_W-1:0] rd_data;
    logic busy, in_xfer, rd_pend_reg, rd_oob_reg, in_range;
    logic [IDX_W-1:0] idx;
    logic start_reg;
    logic out_full_reg;
    logic [DIST_W-1:0] out_reg;

    assign idx = s_tdata[IDX_W-1:0];
    assign in_range = ({14'd0, idx} < 32'(DEPTH));
    assign s_tready = !busy && !start_reg && !rd_pend_reg && !out_full_reg;
    assign in_xfer = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb begin
        io_cmd = '0;
        io_cmd.wr_en = in_xfer && (s_tuser == REQ_LOAD) && in_range;
        io_cmd.wr_addr = idx;
        io_cmd.wr_data = {30'd0, s_tdata[IDX_W]};
        io_cmd.rd_en = in_xfer && (s_tuser == REQ_READ);
        io_cmd.rd_addr = in_range ? idx : '0;
    end

    assign st_cmd = busy ? tr_cmd : io_cmd;

    sedm_store #(.DEPTH(DEPTH)) u_store (
        .aclk(aclk), .cmd(st_cmd), .rd_data(rd_data)
    );

    sedm_ctrl #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .start(start_reg),
        .num_cols(num_cols_reg), .num_rows(num_rows_reg),
        .rd_data(rd_data), .cmd(tr_cmd), .busy(busy)
    );

    assign m_tvalid = out_full_reg;
    assign m_tdata = {1'b0, out_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_cols_reg <= DIM_W'(512);
            num_rows_reg <= DIM_W'(512);
            start_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
            out_full_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == CFG_COLS) num_cols_reg <= cfg_data;
                else num_rows_reg <= cfg_data;
            end
            start_reg <= in_xfer && (s_tuser == REQ_LOAD) && s_tlast;
            rd_pend_reg <= in_xfer && (s_tuser == REQ_READ);
            if (rd_pend_reg) out_full_reg <= 1'b1;
            else if (m_tready) out_full_reg <= 1'b0;
        end
        rd_oob_reg <= !in_range;
        if (rd_pend_reg) out_reg <= rd_oob_reg ? '0 : rd_data;
    end
endmodule

/* tb/sv/squared_euclidean_distance_map_unit_tb.sv */
// testbench for the squared euclidean distance map unit
// loads small random images, runs the transform and checks read-back distances
// depends on sedm_pkg and squared_euclidean_distance_map_unit
module squared_euclidean_distance_map_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sedm_pkg::*;

    class distance_scoreboard;
        int unsigned dist_mem[int];
        int written_q[$];
        int unsigned cols_reg = 512;
        int unsigned rows_reg = 512;
        logic [DIST_W-1:0] pending_q[$];
        int errors = 0;

        function int unsigned clamp_dim(int unsigned v);
            if (v < 1) return 1;
            if (v > 512) return 512;
            return v;
        endfunction

        function int unsigned width_now();
            return clamp_dim(cols_reg);
        endfunction

        function int unsigned height_now();
            return clamp_dim(rows_reg);
        endfunction

        function void write_reg(logic idx, int unsigned v);
            if (idx == CFG_COLS) cols_reg = v & 32'h3FF;
            else rows_reg = v & 32'h3FF;
        endfunction

        function bit relax(int dst, int src, int unsigned inc);
            int unsigned cand;
            cand = dist_mem[src] + inc;
            if (dist_mem[dst] > cand) begin
                dist_mem[dst] = cand;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void run_transform();
            int unsigned w, h, fill_val, inc;
            int eq[512], wq[512], eqn[512], wqn[512];
            int ne, nw, nen, nwn, i, base;
            bit hit;
            w = width_now();
            h = height_now();
            fill_val = 32'd2147483647 - w * w - h * h;
            for (int k = 0; k < w * h; k++)
                if (dist_mem[k] != 0) dist_mem[k] = fill_val;
            for (int c = 0; c < w; c++) begin
                inc = 1;
                for (int r = 1; r < h; r++) begin
                    hit = relax(c + r * w, c + (r - 1) * w, inc);
                    inc = hit ? inc + 2 : 1;
                end
                inc = 1;
                for (int r = int'(h) - 2; r >= 0; r--) begin
                    hit = relax(c + r * w, c + (r + 1) * w, inc);
                    inc = hit ? inc + 2 : 1;
                end
            end
            for (int r = 0; r < h; r++) begin
                base = r * w;
                for (int k = 0; k + 1 < w; k++) begin
                    wq[k] = k + 1;
                    eq[k] = w - 2 - k;
                end
                ne = w - 1;
                nw = w - 1;
                inc = 1;
                while (ne > 0 || nw > 0) begin
                    nen = 0;
                    nwn = 0;
                    for (int q = 0; q < ne; q++) begin
                        i = eq[q];
                        if (relax(base + i + 1, base + i, inc) && i + 2 < w) begin
                            eqn[nen] = i + 1;
                            nen++;
                        end
                    end
                    for (int q = 0; q < nw; q++) begin
                        i = wq[q];
                        if (relax(base + i - 1, base + i, inc) && i > 1) begin
                            wqn[nwn] = i - 1;
                            nwn++;
                        end
                    end
                    for (int q = 0; q < nen; q++) eq[q] = eqn[q];
                    for (int q = 0; q < nwn; q++) wq[q] = wqn[q];
                    ne = nen;
                    nw = nwn;
                    inc += 2;
                end
            end
        endfunction

        function void note_input(logic req, int idx, logic fg, logic fe);
            if (req == REQ_READ) begin
                pending_q.push_back(dist_mem.exists(idx) ? dist_mem[idx][DIST_W-1:0] : '0);
            end else begin
                if (!dist_mem.exists(idx)) written_q.push_back(idx);
                dist_mem[idx] = fg ? 1 : 0;
                if (fe) run_transform();
            end
        endfunction

        function void check_result(logic [31:0] data);
            logic [DIST_W-1:0] want;
            if (pending_q.size() == 0) begin
                $error("unexpected result squared_distance %0d", data[DIST_W-1:0]);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (data[DIST_W-1:0] !== want) begin
                $error("squared_distance expected %0d actual %0d", want, data[DIST_W-1:0]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [9:0]  cfg_data = '0;

    distance_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    squared_euclidean_distance_map_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    task automatic send_item(logic req, int idx, logic fg, logic fe);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tlast <= fe;
        s_tdata <= {5'b0, fg, idx[IDX_W-1:0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(req, idx, fg, fe);
    endtask

    task automatic write_cfg(logic idx, int unsigned v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v[9:0];
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.write_reg(idx, v);
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic read_some(int n, logic fe_flag);
        int w, h, idx;
        w = sb.width_now();
        h = sb.height_now();
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 3) != 0) idx = $urandom_range(0, w * h - 1);
            else idx = sb.written_q[$urandom_range(0, sb.written_q.size() - 1)];
            send_item(REQ_READ, idx, $urandom_range(0, 1), fe_flag & $urandom_range(0, 1));
        end
    endtask

    // one image: config, loads (all or a subset), stray loads, transform, reads
    task automatic run_frame(int unsigned cols, int unsigned rows, int density, int nreads);
        int order[$];
        int w, h, n, tmp, j;
        bit full;
        drain();
        write_cfg(CFG_COLS, cols);
        write_cfg(CFG_ROWS, rows);
        w = sb.width_now();
        h = sb.height_now();
        full = ($urandom_range(0, 2) != 0);
        for (int k = 0; k < w * h; k++) begin
            if (!sb.dist_mem.exists(k)) full = 1'b1;
            order.push_back(k);
        end
        for (int k = order.size() - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        n = full ? order.size() : $urandom_range(1, order.size());
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 9) == 0)
                send_item(REQ_LOAD, $urandom_range(w * h, 262143), $urandom_range(0, 1), 1'b0);
            if ($urandom_range(0, 14) == 0) read_some(1, 1'b1);
            send_item(REQ_LOAD, order[k], $urandom_range(0, 99) < density, k == n - 1);
        end
        read_some(nreads, 1'b1);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: 3x2 image, stray loads at the store top and middle, read with tlast
        write_cfg(CFG_COLS, 3);
        write_cfg(CFG_ROWS, 2);
        send_item(REQ_LOAD, 0, 1'b1, 1'b0);
        send_item(REQ_LOAD, 1, 1'b1, 1'b0);
        send_item(REQ_LOAD, 2, 1'b1, 1'b0);
        send_item(REQ_LOAD, 3, 1'b0, 1'b0);
        send_item(REQ_LOAD, 262143, 1'b1, 1'b0);
        send_item(REQ_LOAD, 131072, 1'b0, 1'b0);
        send_item(REQ_READ, 262143, 1'b1, 1'b1);
        send_item(REQ_LOAD, 4, 1'b1, 1'b0);
        send_item(REQ_LOAD, 5, 1'b1, 1'b1);
        for (int k = 0; k < 6; k++) send_item(REQ_READ, k, 1'b0, 1'b0);
        send_item(REQ_READ, 262143, 1'b0, 1'b0);
        send_item(REQ_READ, 131072, 1'b0, 1'b0);
        // every load is foreground
        run_frame(2, 2, 100, 4);
        // saturated and extreme dimensions
        run_frame(0, 0, 50, 2);
        run_frame(1023, 1, 70, 8);

        for (int f = 0; f < 4; f++) begin
            case (f % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 71; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 71; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            run_frame($urandom_range(1, 9), $urandom_range(1, 7),
                      $urandom_range(0, 9) == 0 ? 100 : $urandom_range(40, 95),
                      $urandom_range(6, 14));
        end
        drain();
        repeat (50) @(posedge aclk);

        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
